@@ src/fvh_pkg.sv @@
// fvh_pkg: shared types and constants for the four-vector histogrammer
// no dependencies
`timescale 1ns / 1ps

package fvh_pkg;

  localparam int unsigned RegIdxW = 2;
  localparam logic [RegIdxW-1:0] RegLowerEdge = 2'd0;
  localparam logic [RegIdxW-1:0] RegUpperEdge = 2'd1;
  localparam logic [RegIdxW-1:0] RegBinsInUse = 2'd2;
  localparam logic [RegIdxW-1:0] RegQtySelect = 2'd3;

  localparam logic [2:0] SelPx   = 3'd0;
  localparam logic [2:0] SelPy   = 3'd1;
  localparam logic [2:0] SelPz   = 3'd2;
  localparam logic [2:0] SelE    = 3'd3;
  localparam logic [2:0] SelMass = 3'd4;

  // operation codes for the shared unit
  typedef enum logic [1:0] {
    OpIdle = 2'd0,
    OpSqrt = 2'd1,
    OpDiv  = 2'd2
  } alu_op_e;

  typedef struct packed {
    logic    go;
    alu_op_e op;
  } alu_ctl_t;

  typedef struct packed {
    logic done;
  } alu_sts_t;

endpackage

@@ src/fvh_alu.sv @@
// fvh_alu: shared one-bit-per-cycle unit for floor square root and division
// depends on fvh_pkg
`timescale 1ns / 1ps

module fvh_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fvh_pkg::alu_ctl_t ctl_i,
  input  logic [63:0]       opa_i,   // radicand, or dividend
  input  logic [63:0]       opb_i,   // divisor
  output fvh_pkg::alu_sts_t sts_o,
  output logic [63:0]       res_o
);

  logic [63:0] rem_q, rem_d;
  logic [63:0] acc_q, acc_d;   // root or quotient
  logic [63:0] opb_q, opb_d;
  logic [63:0] num_q, num_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        sqrt_q, sqrt_d;
  logic        done_q, done_d;

  logic [65:0] trial, remsh;

  always_comb begin
    rem_d  = rem_q;
    acc_d  = acc_q;
    opb_d  = opb_q;
    num_d  = num_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    sqrt_d = sqrt_q;
    done_d = 1'b0;
    trial  = '0;
    remsh  = '0;
    if (ctl_i.go) begin
      busy_d = 1'b1;
      sqrt_d = (ctl_i.op == fvh_pkg::OpSqrt);
      rem_d  = '0;
      acc_d  = '0;
      num_d  = opa_i;
      opb_d  = opb_i;
      cnt_d  = (ctl_i.op == fvh_pkg::OpSqrt) ? 6'd31 : 6'd63;
    end else if (busy_q) begin
      if (sqrt_q) begin
        // restoring square root, two radicand bits per step
        remsh = {rem_q, num_q[63:62]};
        trial = {acc_q, 2'b01};
        num_d = {num_q[61:0], 2'b00};
        if (remsh >= trial) begin
          rem_d = 64'(remsh - trial);
          acc_d = {acc_q[62:0], 1'b1};
        end else begin
          rem_d = remsh[63:0];
          acc_d = {acc_q[62:0], 1'b0};
        end
      end else begin
        // restoring division, one quotient bit per step
        remsh = {1'b0, rem_q, num_q[63]};
        num_d = {num_q[62:0], 1'b0};
        if (remsh >= {2'b00, opb_q}) begin
          rem_d = 64'(remsh - {2'b00, opb_q});
          acc_d = {acc_q[62:0], 1'b1};
        end else begin
          rem_d = remsh[63:0];
          acc_d = {acc_q[62:0], 1'b0};
        end
      end
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      sqrt_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      sqrt_q <= sqrt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    acc_q <= acc_d;
    opb_q <= opb_d;
    num_q <= num_d;
  end

  assign sts_o.done = done_q;
  assign res_o      = acc_q;

endmodule

@@ src/four_vector_histogrammer.sv @@
// four_vector_histogrammer: top level, sequencer, bin store and config registers
// depends on fvh_pkg and fvh_alu
// sequence: a read fetches its bin; an accumulate forms its value and, if in range, counts it
// handshake: one item at a time; a transfer is taken only while busy is low
// reset: async active low, registers take reset values, then a clearing pass
//   zeroes the bin store with busy high; done_o is a one-cycle strobe, no receiver stall
`timescale 1ns / 1ps

module four_vector_histogrammer #(
  parameter int unsigned NUM_BINS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        func_i,
  input  logic signed [31:0] mom_x_i,
  input  logic signed [31:0] mom_y_i,
  input  logic signed [31:0] mom_z_i,
  input  logic signed [31:0] energy_i,
  input  logic [7:0]  read_bin_i,
  output logic        done_o,
  output logic        counted_o,
  output logic [7:0]  hit_bin_o,
  output logic signed [31:0] selected_value_o,
  output logic [31:0] bin_total_o
);

  localparam int unsigned AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned CW = $clog2(NUM_BINS + 1);

  // state codes
  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StSqE   = 4'd2;
  localparam logic [3:0] StSqX   = 4'd3;
  localparam logic [3:0] StSqY   = 4'd4;
  localparam logic [3:0] StSqZ   = 4'd5;
  localparam logic [3:0] StSqrt  = 4'd6;
  localparam logic [3:0] StRange = 4'd7;
  localparam logic [3:0] StDiv   = 4'd8;
  localparam logic [3:0] StRead  = 4'd9;
  localparam logic [3:0] StWrite = 4'd10;
  localparam logic [3:0] StOut   = 4'd11;

  logic [3:0] st_q, st_d;
  logic       sqrt_go_q;   // first cycle of the root state

  // configuration registers
  logic signed [31:0] lower_q, upper_q;
  logic [8:0]         bins_q;
  logic [2:0]         qsel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= '0;
      upper_q <= 32'sd65536;
      bins_q  <= 9'd256;
      qsel_q  <= fvh_pkg::SelMass;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fvh_pkg::RegLowerEdge: lower_q <= cfg_data_i;
        fvh_pkg::RegUpperEdge: upper_q <= cfg_data_i;
        fvh_pkg::RegBinsInUse: bins_q  <= cfg_data_i[8:0];
        fvh_pkg::RegQtySelect: qsel_q  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // item registers
  logic signed [31:0] px_q, py_q, pz_q, e_q;
  logic               func_q;
  logic [7:0]         rbin_q;
  logic [63:0]        msq_q;       // mass squared being formed
  logic               neg_q;       // mass squared went negative
  logic signed [31:0] val_q;       // selected value
  logic               valid_q;     // value defined
  logic               inrng_q;
  logic [63:0]        span_q;
  logic [AW-1:0]      idx_q;
  logic [31:0]        cnt_q;       // count read from the store

  // one shared 32x32 multiplier for the squares, registered
  logic signed [31:0] mul_in;
  logic [31:0]        mag;
  logic [63:0]        sq;
  always_comb begin
    unique case (st_q)
      StSqE:   mul_in = e_q;
      StSqX:   mul_in = px_q;
      StSqY:   mul_in = py_q;
      default: mul_in = pz_q;
    endcase
    mag = mul_in[31] ? 32'(-mul_in) : mul_in;
    sq  = 64'(mag) * 64'(mag);
  end

  // shared sqrt / divide unit
  fvh_pkg::alu_ctl_t alu_ctl;
  fvh_pkg::alu_sts_t alu_sts;
  logic [63:0]       alu_a, alu_b, alu_res;

  fvh_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (alu_ctl),
    .opa_i  (alu_a),
    .opb_i  (alu_b),
    .sts_o  (alu_sts),
    .res_o  (alu_res)
  );

  // clamp of the bin count
  logic [CW-1:0] bins_eff;
  always_comb begin
    if (bins_q == 9'd0) bins_eff = CW'(1);
    else if (32'(bins_q) > NUM_BINS) bins_eff = CW'(NUM_BINS);
    else bins_eff = CW'(bins_q);
  end

  // bin store and clearing pass
  logic [31:0]   mem [NUM_BINS];
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [31:0]   mem_wdata, mem_rdata;
  logic [AW:0]   clr_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata <= mem[mem_addr];
  end

  logic [63:0] q_idx;
  logic [AW-1:0] idx_clamped;
  always_comb begin
    q_idx = alu_res;
    if (q_idx >= 64'(bins_eff)) idx_clamped = AW'(bins_eff - CW'(1));
    else idx_clamped = AW'(q_idx);
  end

  logic inrng;
  always_comb begin
    inrng = (upper_q > lower_q) && (val_q >= lower_q) && (val_q < upper_q);
  end

  // offset into the range, exact in 32 bits while the value is in range
  logic [31:0] off_w;
  logic [40:0] scaled;
  assign off_w  = 32'(val_q - lower_q);
  assign scaled = 41'(off_w) * 41'(bins_eff);

  logic [31:0] cnt_inc;
  assign cnt_inc = (cnt_q == 32'hFFFF_FFFF) ? cnt_q : cnt_q + 32'd1;

  // saturating increment of the word just read from the store
  logic [31:0] rd_inc;
  assign rd_inc = (mem_rdata == 32'hFFFF_FFFF) ? mem_rdata : mem_rdata + 32'd1;

  always_comb begin
    st_d      = st_q;
    alu_ctl   = '{go: 1'b0, op: fvh_pkg::OpIdle};
    alu_a     = '0;
    alu_b     = '0;
    mem_we    = 1'b0;
    mem_addr  = idx_q;
    mem_wdata = rd_inc;
    unique case (st_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q[AW-1:0];
        mem_wdata = '0;
        if (32'(clr_q) == NUM_BINS - 1) st_d = StIdle;
      end
      StIdle: if (start) st_d = StSqE;
      StSqE: begin
        if (func_q) st_d = StRead;
        else if (qsel_q == fvh_pkg::SelMass) st_d = StSqX;
        else st_d = StRange;
      end
      StSqX: st_d = StSqY;
      StSqY: st_d = StSqZ;
      StSqZ: st_d = StSqrt;
      StSqrt: begin
        // first entry starts the unit, later cycles wait for it
        if (!neg_q && sqrt_go_q) begin
          alu_ctl = '{go: 1'b1, op: fvh_pkg::OpSqrt};
          alu_a   = msq_q;
        end
        if (neg_q) st_d = StRange;
        else if (alu_sts.done) st_d = StRange;
      end
      StRange: begin
        if (valid_q && inrng) begin
          alu_ctl = '{go: 1'b1, op: fvh_pkg::OpDiv};
          alu_a   = 64'(scaled);
          alu_b   = span_q;
          st_d    = StDiv;
        end else st_d = StOut;
      end
      StDiv: if (alu_sts.done) st_d = StRead;
      StRead: st_d = StWrite;
      StWrite: begin
        mem_we = !func_q;
        st_d   = StOut;
      end
      StOut: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StClear;
      clr_q     <= '0;
      sqrt_go_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      sqrt_go_q <= (st_q == StSqZ);
      if (st_q == StClear) clr_q <= clr_q + 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: if (start) begin
        px_q <= mom_x_i; py_q <= mom_y_i; pz_q <= mom_z_i; e_q <= energy_i;
        func_q <= func_i; rbin_q <= read_bin_i;
        neg_q  <= 1'b0;
      end
      StSqE: begin
        msq_q <= sq;
        idx_q <= AW'(rbin_q);
        unique case (qsel_q)
          fvh_pkg::SelPx: begin val_q <= px_q; valid_q <= 1'b1; end
          fvh_pkg::SelPy: begin val_q <= py_q; valid_q <= 1'b1; end
          fvh_pkg::SelPz: begin val_q <= pz_q; valid_q <= 1'b1; end
          fvh_pkg::SelE:  begin val_q <= e_q;  valid_q <= 1'b1; end
          default: begin val_q <= '0; valid_q <= 1'b0; end
        endcase
      end
      StSqX, StSqY, StSqZ: begin
        if (msq_q < sq) neg_q <= 1'b1;
        msq_q <= msq_q - sq;
      end
      StSqrt: begin
        if (neg_q) begin
          val_q <= '0; valid_q <= 1'b0;
        end else if (alu_sts.done) begin
          val_q   <= (alu_res > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : alu_res[31:0];
          valid_q <= 1'b1;
        end
      end
      default: ;
    endcase
    if (st_d == StRange) begin
      span_q <= 64'(upper_q) - 64'(lower_q);
    end
    if (st_q == StRange) begin
      inrng_q <= valid_q && inrng;
    end
    if (st_q == StSqE) inrng_q <= 1'b0;
    if (st_q == StDiv && alu_sts.done) idx_q <= idx_clamped;
    if (st_q == StWrite) cnt_q <= mem_rdata;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0; counted_o <= 1'b0; hit_bin_o <= '0;
      selected_value_o <= '0; bin_total_o <= '0;
    end else begin
      done_o <= (st_q == StOut);
      if (st_q == StOut) begin
        if (func_q) begin
          counted_o <= 1'b0; hit_bin_o <= rbin_q; selected_value_o <= '0;
          bin_total_o <= (32'(rbin_q) < NUM_BINS) ? cnt_q : '0;
        end else begin
          counted_o <= inrng_q;
          hit_bin_o <= inrng_q ? 8'(idx_q) : '0;
          selected_value_o <= valid_q ? val_q : '0;
          bin_total_o <= inrng_q ? cnt_inc : '0;
        end
      end
    end
  end

  assign busy = (st_q != StIdle);

  // a result comes only from the output state
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(st_q) == StOut) else $error("result without output state");
  // no transfer is taken while the clearing pass runs
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StClear |-> busy) else $error("idle during clear");
  // a counted result always has a nonzero total
  a_cnt_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && counted_o) |-> bin_total_o != 32'd0) else $error("counted with zero total");

endmodule

@@ bench/four_vector_histogrammer_tb.sv @@
// four_vector_histogrammer_tb: self-checking bench for the four-vector histogrammer
// depends on fvh_pkg and the four_vector_histogrammer rtl
// a bin-count predictor mirrors every accepted transfer and checks each done_o strobe
`timescale 1ns / 1ps

// one expected histogram response
typedef struct {
  bit               counted;
  bit [7:0]         hit_bin;
  bit signed [31:0] sel_value;
  bit [31:0]        total;
} hist_resp_t;

// predictor and checker for the bin store
class hist_scoreboard;
  longint           lo_edge;
  longint           hi_edge;
  int unsigned      n_bins;
  bit [2:0]         qty_sel;
  bit [31:0]        counts[256];
  hist_resp_t       resp_q[$];
  int unsigned      errors;
  int unsigned      mismatches;

  function new();
    lo_edge = 0;
    hi_edge = 65536;
    n_bins  = 256;
    qty_sel = fvh_pkg::SelMass;
    foreach (counts[i]) counts[i] = '0;
    errors = 0;
    mismatches = 0;
  endfunction

  function void write_reg(bit [1:0] idx, bit [31:0] data);
    case (idx)
      fvh_pkg::RegLowerEdge: lo_edge = longint'($signed(data));
      fvh_pkg::RegUpperEdge: hi_edge = longint'($signed(data));
      fvh_pkg::RegBinsInUse: n_bins  = data[8:0];
      fvh_pkg::RegQtySelect: qty_sel = data[2:0];
      default: ;
    endcase
  endfunction

  function longint unsigned mag_sq(longint v);
    longint unsigned a;
    a = (v < 0) ? longint'(-v) : longint'(v);
    return a * a;
  endfunction

  // bitwise floor square root of a 64-bit value
  function longint unsigned floor_sqrt(longint unsigned d);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > d) b >>= 2;
    while (b != 0) begin
      if (d >= root + b) begin
        d -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // accepted input: work out the response and update the bin store
  function void note_item(bit func, bit signed [31:0] px, bit signed [31:0] py,
                          bit signed [31:0] pz, bit signed [31:0] en, bit [7:0] rbin);
    hist_resp_t r;
    longint v;
    longint unsigned d, s, span, off, idx, nb;
    bit ok;
    r = '{0, 0, 0, 0};
    if (func) begin
      r.hit_bin = rbin;
      r.total = counts[rbin];
      resp_q = {resp_q, r};
      return;
    end
    ok = 1;
    case (qty_sel)
      fvh_pkg::SelPx:   v = px;
      fvh_pkg::SelPy:   v = py;
      fvh_pkg::SelPz:   v = pz;
      fvh_pkg::SelE:    v = en;
      fvh_pkg::SelMass: begin
        d = mag_sq(en);
        s = mag_sq(px);
        if (d < s) ok = 0; else d -= s;
        s = mag_sq(py);
        if (ok && d < s) ok = 0; else if (ok) d -= s;
        s = mag_sq(pz);
        if (ok && d < s) ok = 0; else if (ok) d -= s;
        if (ok) begin
          d = floor_sqrt(d);
          if (d > 64'h7FFF_FFFF) d = 64'h7FFF_FFFF;
          v = longint'(d);
        end
      end
      default: ok = 0;   // unused selector
    endcase
    if (ok) begin
      r.sel_value = v[31:0];
      if (hi_edge > lo_edge && v >= lo_edge && v < hi_edge) begin
        nb = (n_bins == 0) ? 1 : (n_bins > 256 ? 256 : n_bins);
        span = hi_edge - lo_edge;
        off = v - lo_edge;
        idx = (off * nb) / span;
        if (idx >= nb) idx = nb - 1;
        if (counts[idx] != 32'hFFFF_FFFF) counts[idx]++;
        r.counted = 1;
        r.hit_bin = idx[7:0];
        r.total = counts[idx];
      end
    end
    resp_q = {resp_q, r};
  endfunction

  function void check_resp(bit counted, bit [7:0] hit_bin, bit [31:0] sel_value,
                           bit [31:0] total);
    hist_resp_t e;
    if (resp_q.size() == 0) begin
      errors++;
      if (mismatches++ < 10) $display("unexpected result strobe, bin %0d", hit_bin);
      return;
    end
    e = resp_q.pop_front();
    if (e.counted !== counted || e.hit_bin !== hit_bin || e.sel_value !== sel_value ||
        e.total !== total) begin
      errors++;
      if (mismatches++ < 10)
        $display("mismatch: exp cnt %0b bin %0d val %0d tot %0d / got %0b %0d %0d %0d",
                 e.counted, e.hit_bin, e.sel_value, e.total,
                 counted, hit_bin, $signed(sel_value), total);
    end
  endfunction

  function int unsigned pending();
    return resp_q.size();
  endfunction
endclass

module four_vector_histogrammer_tb;

  localparam bit FuncAccum = 1'b0;
  localparam bit FuncRead  = 1'b1;
  localparam logic [2:0] SelUnused = 3'd6;
  // settle a bit beyond the slowest accumulate
  localparam int SettleCycles = 150;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [31:0]        cfg_data_i;
  logic               func_i;
  logic signed [31:0] mom_x_i, mom_y_i, mom_z_i, energy_i;
  logic [7:0]         read_bin_i;
  logic               done_o;
  logic               counted_o;
  logic [7:0]         hit_bin_o;
  logic signed [31:0] selected_value_o;
  logic [31:0]        bin_total_o;

  hist_scoreboard sb;

  four_vector_histogrammer uut (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .func_i, .mom_x_i, .mom_y_i, .mom_z_i, .energy_i, .read_bin_i,
    .done_o, .counted_o, .hit_bin_o, .selected_value_o, .bin_total_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // safety net well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // result side: every strobe is a transfer, no stall possible
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_resp(counted_o, hit_bin_o, selected_value_o, bin_total_o);
  end

  // register write while idle, mirrored into the predictor
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // one command transfer; start stays high across zero-gap back-to-back items
  task automatic send_item(input bit func, input logic signed [31:0] px,
                           input logic signed [31:0] py, input logic signed [31:0] pz,
                           input logic signed [31:0] en, input logic [7:0] rbin);
    int gap;
    bit taken;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;   // some stretches with no idling
    if (gap > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start = 1'b1;
    func_i = func;
    mom_x_i = px;
    mom_y_i = py;
    mom_z_i = pz;
    energy_i = en;
    read_bin_i = rbin;
    taken = 0;
    while (!taken) begin
      @(posedge clk_i);
      if (!busy) taken = 1;
    end
    sb.note_item(func, px, py, pz, en, rbin);
  endtask

  // drop start and let every pending result come home, then settle
  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      3: return $signed($urandom_range(0, 8191)) - 4096;
      default: return $urandom;
    endcase
  endfunction

  // value inside the active range when one exists
  function automatic logic [31:0] in_range_word();
    longint span;
    span = sb.hi_edge - sb.lo_edge;
    if (span <= 0) return rand_word();
    return sb.lo_edge + longint'({$urandom, $urandom} % longint'(span));
  endfunction

  task automatic accum_random();
    logic signed [31:0] px, py, pz, en;
    longint unsigned e_mag;
    if (sb.qty_sel == fvh_pkg::SelMass && $urandom_range(0, 9) < 8) begin
      // physical vector: energy dominates the momentum
      e_mag = $urandom_range(0, (1 << ($urandom_range(4, 30)))) ;
      en = e_mag;
      px = $signed($urandom_range(0, e_mag / 2)) * ($urandom_range(0, 1) ? 1 : -1);
      py = $signed($urandom_range(0, e_mag / 2)) * ($urandom_range(0, 1) ? 1 : -1);
      pz = $signed($urandom_range(0, e_mag / 2)) * ($urandom_range(0, 1) ? 1 : -1);
      if ($urandom_range(0, 9) == 0) en = -en;
    end else begin
      px = rand_word();
      py = rand_word();
      pz = rand_word();
      en = rand_word();
      if ($urandom_range(0, 9) < 7) begin
        case (sb.qty_sel)
          fvh_pkg::SelPx: px = in_range_word();
          fvh_pkg::SelPy: py = in_range_word();
          fvh_pkg::SelPz: pz = in_range_word();
          fvh_pkg::SelE:  en = in_range_word();
          default: ;
        endcase
      end
    end
    send_item(FuncAccum, px, py, pz, en, $urandom);
  endtask

  task automatic random_config();
    logic [31:0] lo, hi;
    int unsigned sel;
    case ($urandom_range(0, 4))
      0: begin lo = 0; hi = $urandom_range(1, 1 << 26); end
      1: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
      2: begin
        lo = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
        hi = lo + $urandom_range(1, 1 << 20);
      end
      3: begin lo = $urandom; hi = lo - $urandom_range(0, 1000); end   // empty or inverted
      default: begin lo = $urandom; hi = $urandom; end
    endcase
    sel = $urandom_range(0, 9);
    if (sel > 7) sel = fvh_pkg::SelMass;
    write_reg(fvh_pkg::RegLowerEdge, lo);
    write_reg(fvh_pkg::RegUpperEdge, hi);
    write_reg(fvh_pkg::RegBinsInUse, $urandom_range(0, 3) == 0 ? $urandom_range(0, 511)
                                                               : $urandom_range(1, 256));
    write_reg(fvh_pkg::RegQtySelect, sel);
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    func_i = FuncAccum;
    mom_x_i = '0;
    mom_y_i = '0;
    mom_z_i = '0;
    energy_i = '0;
    read_bin_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset config, mass into 0..256 MeV over 256 bins
    send_item(FuncRead, 0, 0, 0, 0, 8'd0);
    send_item(FuncRead, 0, 0, 0, 0, 8'd255);
    send_item(FuncAccum, 0, 0, 0, 0, 0);                         // zero mass
    send_item(FuncAccum, 0, 0, 0, 32'sd25600, 0);                // mass 100 MeV
    send_item(FuncAccum, 3 << 8, 4 << 8, 0, 5 << 8, 0);          // light-like, mass 0
    send_item(FuncAccum, 32'sd1000, 0, 0, 32'sd10, 0);           // negative mass squared
    send_item(FuncAccum, 0, 0, 0, 32'h8000_0000, 0);             // mass saturates, out of range
    send_item(FuncAccum, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'hFF);
    send_item(FuncAccum, 0, 0, 0, 32'sd65535, 0);                // top bin
    send_item(FuncRead, 0, 0, 0, 0, 8'd0);
    drain();
    // selectors on the full signed range, bins beyond the store
    write_reg(fvh_pkg::RegLowerEdge, 32'h8000_0000);
    write_reg(fvh_pkg::RegUpperEdge, 32'h7FFF_FFFF);
    write_reg(fvh_pkg::RegBinsInUse, 9'd511);
    for (int q = fvh_pkg::SelPx; q <= fvh_pkg::SelE; q++) begin
      write_reg(fvh_pkg::RegQtySelect, q);
      send_item(FuncAccum, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFE, 0);
      send_item(FuncAccum, 32'h7FFF_FFFE, 32'h8000_0000, 0, 32'h8000_0000, 0);
      drain();
    end
    write_reg(fvh_pkg::RegBinsInUse, 9'd0);                      // acts as one bin
    send_item(FuncAccum, 32'sd5, 0, 0, 32'sd7, 0);
    drain();
    write_reg(fvh_pkg::RegQtySelect, SelUnused);                 // unused selector
    send_item(FuncAccum, 32'sd5, 0, 0, 32'sd7, 0);
    drain();
    write_reg(fvh_pkg::RegQtySelect, fvh_pkg::SelPx);
    write_reg(fvh_pkg::RegUpperEdge, 32'h8000_0000);             // empty range
    send_item(FuncAccum, 32'h8000_0000, 0, 0, 0, 0);
    drain();
    write_reg(fvh_pkg::RegLowerEdge, 0);
    write_reg(fvh_pkg::RegUpperEdge, 32'sd256);
    write_reg(fvh_pkg::RegBinsInUse, 9'd1);
    send_item(FuncAccum, 32'sd255, 0, 0, 0, 0);
    send_item(FuncAccum, 32'sd256, 0, 0, 0, 0);                  // upper edge is exclusive
    drain();

    // random phases, each ends with a full pause so config stays idle-only
    for (int ph = 0; ph < 11; ph++) begin
      random_config();
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 4) == 0) send_item(FuncRead, rand_word(), rand_word(),
                                                 rand_word(), rand_word(), $urandom);
        else accum_random();
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
